/* src/tetpt_pkg.sv */
// Package for the timestamped entry priority table.
// Entry type, cell control struct, operation and status codes, calendar helpers.
// No dependencies.
`default_nettype none
package tetpt_pkg;

  localparam int CAPACITY = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int KEY_W    = 36;

  localparam logic [2:0] OP_INSERT    = 3'd0;
  localparam logic [2:0] OP_COUNT     = 3'd1;
  localparam logic [2:0] OP_REM_EARLY = 3'd2;
  localparam logic [2:0] OP_REM_OWNER = 3'd3;
  localparam logic [2:0] OP_CLEAR     = 3'd4;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_DATE  = 3'd1;
  localparam logic [2:0] ST_TIME  = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  localparam logic [4:0] MAX_HOUR   = 5'd23;
  localparam logic [5:0] MAX_MINUTE = 6'd59;
  localparam logic [3:0] MAX_MONTH  = 4'd12;

  // floor(y / 25) for 16-bit y is (y * RECIP25) >> RECIP25_SH
  localparam logic [18:0] RECIP25    = 19'd335545;
  localparam int          RECIP25_SH = 23;

  typedef struct packed {
    logic [15:0] owner;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } entry_t;

  typedef struct packed {
    logic take_new;
    logic take_right;
    logic take_head;
  } cell_ctl_t;

  function automatic logic [KEY_W-1:0] order_key(input entry_t e);
    return {e.year, e.month, e.day, e.hour, e.minute};
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

/* src/tetpt_cell.sv */
// One slot of the entry chain: holds an entry, takes its right neighbor,
// the chain head (recirculation) or a new entry. Depends on tetpt_pkg.
`default_nettype none
module tetpt_cell (
  input  wire                  clk,
  input  tetpt_pkg::cell_ctl_t ctl,
  input  tetpt_pkg::entry_t    right,
  input  tetpt_pkg::entry_t    head,
  input  tetpt_pkg::entry_t    new_entry,
  output tetpt_pkg::entry_t    q
);
  import tetpt_pkg::*;

  entry_t slot_r;

  always_ff @(posedge clk) begin
    if (ctl.take_new) begin
      slot_r <= new_entry;
    end else if (ctl.take_right) begin
      slot_r <= right;
    end else if (ctl.take_head) begin
      slot_r <= head;
    end
  end

  assign q = slot_r;

endmodule
`default_nettype wire

/* src/timestamped_entry_priority_table.sv */
// Top level of the timestamped entry priority table: control, calendar check
// and the chain of tetpt_cell slots. Depends on tetpt_pkg and tetpt_cell.
//
// Usage:
//   Input channel in_*: one request per operation (insert, count on date,
//   remove earliest, remove owner, clear). Result channel out_*: one result
//   per request with status, entry count, match count and earliest entry.
//   cfg_*: write of capacity_in_use, taken only while the block is idle.
// Flow: each accepted request passes S_MUL, S_EXEC and S_FIN before out_valid.
//   Count with a valid date, remove earliest and remove owner on a non-empty
//   table also pass S_SCAN, rotating the chain once, one entry per cycle
//   through cell 0, for the N entries held (up to 32). One request is in work
//   at a time; in_ready is high only when the block is idle.
// Reset: table empty, capacity_in_use 32, no result pending.
// Stall: the result sits in an output register; a new request is accepted
//   while it waits, and the next result is held until the current one is taken.
`default_nettype none
module timestamped_entry_priority_table (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [5:0]  cfg_capacity_in_use,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [2:0]  in_operation,
  input  wire  [15:0] in_owner_id,
  input  wire  [15:0] in_year,
  input  wire  [3:0]  in_month,
  input  wire  [4:0]  in_day,
  input  wire  [4:0]  in_hour,
  input  wire  [5:0]  in_minute,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [2:0]  out_status,
  output logic [5:0]  out_entry_count,
  output logic [5:0]  out_match_count,
  output logic        out_earliest_valid,
  output logic [15:0] out_earliest_owner,
  output logic [15:0] out_earliest_year,
  output logic [3:0]  out_earliest_month,
  output logic [4:0]  out_earliest_day,
  output logic [4:0]  out_earliest_hour,
  output logic [5:0]  out_earliest_minute
);
  import tetpt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_EXEC = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]       state_r;
  logic [2:0]       op_r;
  entry_t           req_r;
  logic [11:0]      q25_r;
  logic [5:0]       cap_r;
  logic [CNT_W-1:0] total_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cur_t_r;
  logic [CNT_W-1:0] kept_r;
  logic [CNT_W-1:0] match_r;
  logic [2:0]       stat_r;
  entry_t           best_r;
  logic [IDX_W-1:0] eidx_r;
  logic [IDX_W-1:0] drop_idx_r;
  logic             out_valid_r;
  logic [2:0]       o_status_r;
  logic [5:0]       o_count_r;
  logic [5:0]       o_match_r;
  logic             o_ev_r;
  entry_t           o_e_r;

  entry_t    cell_q   [CAPACITY];
  cell_ctl_t cell_ctl [CAPACITY];
  entry_t    head;

  logic [34:0]      prod;
  logic [16:0]      q25x;
  logic             div25, leap, date_ok, time_ok;
  logic [CNT_W-1:0] limit;
  logic             scan_go, drop, ins_commit, out_load;
  logic [2:0]       exec_stat;
  logic             exec_scan;

  assign head = cell_q[0];

  // calendar check; q25_r is registered in S_MUL, in the cycle before its use in S_EXEC
  assign prod  = 35'(req_r.year) * 35'(RECIP25);
  assign q25x  = 17'(q25_r) * 17'd25;
  assign div25 = (q25x == {1'b0, req_r.year});
  assign leap  = ((req_r.year[1:0] == 2'd0) && !div25) ||
                 ((req_r.year[3:0] == 4'd0) && div25);
  assign date_ok = (req_r.year != 16'd0) && (req_r.month != 4'd0) &&
                   (req_r.month <= MAX_MONTH) && (req_r.day != 5'd0) &&
                   (req_r.day <= month_len(req_r.month, leap));
  assign time_ok = (req_r.hour <= MAX_HOUR) && (req_r.minute <= MAX_MINUTE);

  assign limit = (cap_r >= 6'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(cap_r);

  assign ins_commit = (state_r == S_EXEC) && (op_r == OP_INSERT) &&
                      (total_r < limit) && date_ok && time_ok;
  assign scan_go    = (state_r == S_SCAN);
  assign drop = ((op_r == OP_REM_OWNER) && (head.owner == req_r.owner)) ||
                ((op_r == OP_REM_EARLY) && (cnt_r[IDX_W-1:0] == drop_idx_r));

  // status and scan decision for the request in S_EXEC
  always_comb begin
    exec_stat = ST_OK;
    exec_scan = 1'b0;
    case (op_r)
      OP_INSERT: begin
        if (total_r >= limit) begin
          exec_stat = ST_FULL;
        end else if (!date_ok) begin
          exec_stat = ST_DATE;
        end else if (!time_ok) begin
          exec_stat = ST_TIME;
        end
      end
      OP_COUNT: begin
        if (!date_ok) begin
          exec_stat = ST_DATE;
        end else begin
          exec_scan = (total_r != '0);
        end
      end
      OP_REM_EARLY: begin
        if (total_r == '0) begin
          exec_stat = ST_EMPTY;
        end else begin
          exec_scan = 1'b1;
        end
      end
      OP_REM_OWNER: begin
        exec_scan = (total_r != '0);
      end
      default: begin
      end
    endcase
  end

  // head leaves cell 0; the rest shifts left; a kept head re-enters at the tail
  always_comb begin
    for (int j = 0; j < CAPACITY; j++) begin
      cell_ctl[j].take_new   = ins_commit && (CNT_W'(j) == total_r);
      cell_ctl[j].take_right = scan_go && ((CNT_W'(j) + 1'b1) < cur_t_r);
      cell_ctl[j].take_head  = scan_go && !drop && ((CNT_W'(j) + 1'b1) == cur_t_r);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    entry_t right;
    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_mid
      assign right = cell_q[g+1];
    end
    tetpt_cell u_cell (
      .clk       (clk),
      .ctl       (cell_ctl[g]),
      .right     (right),
      .head      (head),
      .new_entry (req_r),
      .q         (cell_q[g])
    );
  end

  assign cfg_ready = (state_r == S_IDLE);
  assign in_ready  = (state_r == S_IDLE);
  assign out_load  = (state_r == S_FIN) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      cap_r       <= 6'd32;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity_in_use;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          state_r <= exec_scan ? S_SCAN : S_FIN;
          if (ins_commit) begin
            total_r <= total_r + 1'b1;
          end else if (op_r == OP_CLEAR) begin
            total_r <= '0;
          end
        end
        S_SCAN: begin
          if ((cnt_r + 1'b1) == total_r) begin
            total_r <= drop ? cur_t_r - 1'b1 : cur_t_r;
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      op_r         <= in_operation;
      req_r.owner  <= in_owner_id;
      req_r.year   <= in_year;
      req_r.month  <= in_month;
      req_r.day    <= in_day;
      req_r.hour   <= in_hour;
      req_r.minute <= in_minute;
    end
    if (state_r == S_MUL) begin
      q25_r <= prod[RECIP25_SH+11:RECIP25_SH];
    end
    if (state_r == S_EXEC) begin
      cnt_r      <= '0;
      cur_t_r    <= total_r;
      kept_r     <= '0;
      match_r    <= '0;
      drop_idx_r <= eidx_r;
      stat_r     <= exec_stat;
      if (ins_commit && ((total_r == '0) || (order_key(req_r) < order_key(best_r)))) begin
        best_r <= req_r;
        eidx_r <= total_r[IDX_W-1:0];
      end
    end
    if (scan_go) begin
      cnt_r <= cnt_r + 1'b1;
      if (drop) begin
        cur_t_r <= cur_t_r - 1'b1;
      end else begin
        kept_r <= kept_r + 1'b1;
        if ((kept_r == '0) || (order_key(head) < order_key(best_r))) begin
          best_r <= head;
          eidx_r <= kept_r[IDX_W-1:0];
        end
      end
      if ((op_r == OP_COUNT) && (head.year == req_r.year) &&
          (head.month == req_r.month) && (head.day == req_r.day)) begin
        match_r <= match_r + 1'b1;
      end
    end
    if (out_load) begin
      o_status_r <= stat_r;
      o_count_r  <= 6'(total_r);
      o_match_r  <= 6'(match_r);
      o_ev_r     <= (total_r != '0);
      o_e_r      <= (total_r != '0) ? best_r : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = o_status_r;
  assign out_entry_count     = o_count_r;
  assign out_match_count     = o_match_r;
  assign out_earliest_valid  = o_ev_r;
  assign out_earliest_owner  = o_e_r.owner;
  assign out_earliest_year   = o_e_r.year;
  assign out_earliest_month  = o_e_r.month;
  assign out_earliest_day    = o_e_r.day;
  assign out_earliest_hour   = o_e_r.hour;
  assign out_earliest_minute = o_e_r.minute;

endmodule
`default_nettype wire

/* src/tetpt_checker.sv */
// Port-level checks for the timestamped entry priority table, bound to the top.
// Depends on tetpt_pkg and timestamped_entry_priority_table.
`default_nettype none
module tetpt_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire [5:0]  out_entry_count,
  input wire [5:0]  out_match_count,
  input wire        out_earliest_valid,
  input wire [15:0] out_earliest_owner,
  input wire [15:0] out_earliest_year
);
  import tetpt_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_ev_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_earliest_valid == (out_entry_count != 6'd0)))
    else $error("earliest valid disagrees with entry count");

  a_match_le: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_match_count <= out_entry_count))
    else $error("match count above entry count");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_earliest_valid |->
      (out_earliest_owner == 16'd0) && (out_earliest_year == 16'd0))
    else $error("earliest fields not cleared on empty table");

endmodule

bind timestamped_entry_priority_table tetpt_checker u_tetpt_checker (.*);
`default_nettype wire

/* verif/testbench.sv */
// Testbench for timestamped_entry_priority_table: directed table of requests,
// then random operation mixes, all checked against a behavioral table model.
// Depends on tetpt_pkg and the block's RTL.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import tetpt_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  entry_count;
    logic [5:0]  match_count;
    logic        earliest_valid;
    logic [15:0] owner;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
  } table_result_t;

  typedef struct {
    logic [2:0]  op;
    logic [15:0] owner;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic        has_fixed;
    logic [2:0]  fixed_status;
  } request_t;

  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [5:0] cfg_capacity_in_use = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_operation = '0;
  logic [15:0] in_owner_id = '0, in_year = '0;
  logic [3:0] in_month = '0;
  logic [4:0] in_day = '0, in_hour = '0;
  logic [5:0] in_minute = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_status;
  logic [5:0] out_entry_count, out_match_count;
  logic out_earliest_valid;
  logic [15:0] out_earliest_owner, out_earliest_year;
  logic [3:0] out_earliest_month;
  logic [4:0] out_earliest_day, out_earliest_hour;
  logic [5:0] out_earliest_minute;

  timestamped_entry_priority_table i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_capacity_in_use(cfg_capacity_in_use),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_owner_id(in_owner_id), .in_year(in_year), .in_month(in_month), .in_day(in_day),
    .in_hour(in_hour), .in_minute(in_minute),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_entry_count(out_entry_count), .out_match_count(out_match_count),
    .out_earliest_valid(out_earliest_valid), .out_earliest_owner(out_earliest_owner),
    .out_earliest_year(out_earliest_year), .out_earliest_month(out_earliest_month),
    .out_earliest_day(out_earliest_day), .out_earliest_hour(out_earliest_hour),
    .out_earliest_minute(out_earliest_minute)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // table model
  entry_t        shadow_entries[$];
  logic [5:0]    shadow_capacity = 6'd32;
  table_result_t pending_results[$];
  logic [2:0]    pending_fixed[$];   // expected status for directed and full-table rows, or 3'h7 = none
  int            errors = 0;
  int            cycles = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;

  function automatic logic calendar_ok(logic [15:0] y, logic [3:0] m, logic [4:0] d);
    logic leap;
    int len;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    if (y == 0 || m < 1 || m > 12 || d < 1) return 1'b0;
    case (m)
      4, 6, 9, 11: len = 30;
      2:           len = leap ? 29 : 28;
      default:     len = 31;
    endcase
    return d <= len;
  endfunction

  function automatic logic [35:0] sort_key(entry_t e);
    return {e.year, e.month, e.day, e.hour, e.minute};
  endfunction

  function automatic int earliest_slot();
    int best;
    best = 0;
    for (int i = 1; i < shadow_entries.size(); i++)
      if (sort_key(shadow_entries[i]) < sort_key(shadow_entries[best])) best = i;
    return best;
  endfunction

  function automatic table_result_t apply_request(request_t r);
    table_result_t res;
    entry_t e;
    int limit, i;
    res = '0;
    res.status = ST_OK;
    limit = (int'(shadow_capacity) < CAPACITY) ? int'(shadow_capacity) : CAPACITY;
    case (r.op)
      OP_INSERT: begin
        if (shadow_entries.size() >= limit) res.status = ST_FULL;
        else if (!calendar_ok(r.year, r.month, r.day)) res.status = ST_DATE;
        else if (r.hour > MAX_HOUR || r.minute > MAX_MINUTE) res.status = ST_TIME;
        else begin
          e = '{owner: r.owner, year: r.year, month: r.month, day: r.day,
                hour: r.hour, minute: r.minute};
          shadow_entries.insert(shadow_entries.size(), e);
        end
      end
      OP_COUNT: begin
        if (!calendar_ok(r.year, r.month, r.day)) res.status = ST_DATE;
        else
          foreach (shadow_entries[k])
            if (shadow_entries[k].year == r.year && shadow_entries[k].month == r.month &&
                shadow_entries[k].day == r.day) res.match_count++;
      end
      OP_REM_EARLY: begin
        if (shadow_entries.size() == 0) res.status = ST_EMPTY;
        else shadow_entries.delete(earliest_slot());
      end
      OP_REM_OWNER: begin
        i = 0;
        while (i < shadow_entries.size()) begin
          if (shadow_entries[i].owner == r.owner) shadow_entries.delete(i);
          else i++;
        end
      end
      OP_CLEAR: shadow_entries.delete();
      default: ;
    endcase
    res.entry_count = 6'(shadow_entries.size());
    if (shadow_entries.size() > 0) begin
      e = shadow_entries[earliest_slot()];
      res.earliest_valid = 1'b1;
      res.owner = e.owner; res.year = e.year; res.month = e.month;
      res.day = e.day; res.hour = e.hour; res.minute = e.minute;
    end
    return res;
  endfunction

  // valid stays high from one request into the next unless the sender idles
  task automatic send_request(request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= r.op; in_owner_id <= r.owner; in_year <= r.year;
    in_month <= r.month; in_day <= r.day; in_hour <= r.hour; in_minute <= r.minute;
    do @(posedge clk); while (!in_ready);
    pending_results.insert(pending_results.size(), apply_request(r));
    pending_fixed.insert(pending_fixed.size(), r.has_fixed ? r.fixed_status : 3'h7);
  endtask

  task automatic drain_and_configure(logic [5:0] cap);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_capacity_in_use <= cap;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_capacity = cap;
  endtask

  function automatic request_t rand_request();
    request_t r;
    int pick;
    r.has_fixed = 1'b0;
    r.fixed_status = ST_OK;
    pick = $urandom_range(99);
    if (pick < 45) r.op = OP_INSERT;
    else if (pick < 65) r.op = OP_COUNT;
    else if (pick < 80) r.op = OP_REM_EARLY;
    else if (pick < 92) r.op = OP_REM_OWNER;
    else if (pick < 96) r.op = OP_CLEAR;
    else r.op = 3'($urandom_range(7));
    // narrow owners and dates so removals and date matches hit
    r.owner = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(5));
    if ($urandom_range(9) == 0) begin
      r.year = 16'($urandom); r.month = 4'($urandom); r.day = 5'($urandom);
      r.hour = 5'($urandom); r.minute = 6'($urandom);
    end else begin
      r.year = 16'($urandom_range(2000, 2002));
      r.month = 4'($urandom_range(1, 3));
      r.day = 5'($urandom_range(27, 29));
      r.hour = 5'($urandom_range(23));
      r.minute = 6'($urandom_range(59));
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rst_n && out_valid && out_ready) begin
      table_result_t got, want;
      logic [2:0] fixed;
      got = '{out_status, out_entry_count, out_match_count, out_earliest_valid,
              out_earliest_owner, out_earliest_year, out_earliest_month,
              out_earliest_day, out_earliest_hour, out_earliest_minute};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        fixed = pending_fixed.pop_front();
        if (fixed != 3'h7 && got.status != fixed) begin
          $display("%0t: status expected %0d actual %0d", $time, fixed, got.status);
          errors++;
        end
        if (got.status != want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status); errors++; end
        if (got.entry_count != want.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time, want.entry_count,
                   got.entry_count); errors++; end
        if (got.match_count != want.match_count) begin
          $display("%0t: match_count expected %0d actual %0d", $time, want.match_count,
                   got.match_count); errors++; end
        if (got.earliest_valid != want.earliest_valid) begin
          $display("%0t: earliest_valid expected %0d actual %0d", $time, want.earliest_valid,
                   got.earliest_valid); errors++; end
        if (got.owner != want.owner) begin
          $display("%0t: earliest_owner expected %0d actual %0d", $time, want.owner,
                   got.owner); errors++; end
        if (got.year != want.year) begin
          $display("%0t: earliest_year expected %0d actual %0d", $time, want.year,
                   got.year); errors++; end
        if (got.month != want.month) begin
          $display("%0t: earliest_month expected %0d actual %0d", $time, want.month,
                   got.month); errors++; end
        if (got.day != want.day) begin
          $display("%0t: earliest_day expected %0d actual %0d", $time, want.day,
                   got.day); errors++; end
        if (got.hour != want.hour) begin
          $display("%0t: earliest_hour expected %0d actual %0d", $time, want.hour,
                   got.hour); errors++; end
        if (got.minute != want.minute) begin
          $display("%0t: earliest_minute expected %0d actual %0d", $time, want.minute,
                   got.minute); errors++; end
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // directed rows; status 3'h7 means predictor only
  request_t directed[$];
  initial begin
    directed = '{
      '{OP_REM_EARLY, 16'h0, 16'd1, 4'd1, 5'd1, 5'd0, 6'd0, 1'b1, ST_EMPTY},
      '{OP_INSERT, 16'hFFFF, 16'hFFFF, 4'd12, 5'd31, 5'd23, 6'd59, 1'b1, ST_OK},
      '{OP_INSERT, 16'h0, 16'd0, 4'd1, 5'd1, 5'd0, 6'd0, 1'b1, ST_DATE},
      '{OP_INSERT, 16'h1, 16'd1, 4'd0, 5'd1, 5'd0, 6'd0, 1'b1, ST_DATE},
      '{OP_INSERT, 16'h1, 16'd1, 4'd13, 5'd1, 5'd0, 6'd0, 1'b1, ST_DATE},
      '{OP_INSERT, 16'h1, 16'd1, 4'd15, 5'd31, 5'd31, 6'd63, 1'b1, ST_DATE},
      '{OP_INSERT, 16'h1, 16'd1, 4'd1, 5'd0, 5'd0, 6'd0, 1'b1, ST_DATE},
      '{OP_INSERT, 16'h1, 16'd1, 4'd4, 5'd31, 5'd0, 6'd0, 1'b1, ST_DATE},
      '{OP_INSERT, 16'h1, 16'd1900, 4'd2, 5'd29, 5'd0, 6'd0, 1'b1, ST_DATE},
      '{OP_INSERT, 16'h2, 16'd2000, 4'd2, 5'd29, 5'd0, 6'd0, 1'b1, ST_OK},
      '{OP_INSERT, 16'h3, 16'd2004, 4'd2, 5'd29, 5'd10, 6'd5, 1'b1, ST_OK},
      '{OP_INSERT, 16'h3, 16'd2003, 4'd2, 5'd29, 5'd0, 6'd0, 1'b1, ST_DATE},
      '{OP_INSERT, 16'h1, 16'd1, 4'd1, 5'd1, 5'd24, 6'd0, 1'b1, ST_TIME},
      '{OP_INSERT, 16'h1, 16'd1, 4'd1, 5'd1, 5'd0, 6'd60, 1'b1, ST_TIME},
      '{OP_INSERT, 16'h2, 16'd2000, 4'd2, 5'd29, 5'd0, 6'd0, 1'b1, ST_OK},
      '{OP_COUNT, 16'h9, 16'd2000, 4'd2, 5'd29, 5'd31, 6'd63, 1'b1, ST_OK},
      '{OP_COUNT, 16'h0, 16'd2001, 4'd2, 5'd29, 5'd0, 6'd0, 1'b1, ST_DATE},
      '{OP_REM_EARLY, 16'h0, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 1'b1, ST_OK},
      '{OP_REM_OWNER, 16'h7, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 1'b1, ST_OK},
      '{OP_REM_OWNER, 16'h3, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 1'b1, ST_OK},
      '{3'd5, 16'h0, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 1'b1, ST_OK},
      '{3'd7, 16'hFFFF, 16'hFFFF, 4'd15, 5'd31, 5'd31, 6'd63, 1'b1, ST_OK},
      '{OP_CLEAR, 16'h0, 16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 1'b1, ST_OK}
    };
  end

  initial begin
    logic [5:0] caps[5];
    request_t r;
    caps = '{6'd0, 6'd1, 6'd63, 6'd5, 6'd32};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[k]) send_request(directed[k]);
    for (int phase = 0; phase < 5; phase++) begin
      drain_and_configure(caps[phase]);
      send_idle_pct = (phase < 2) ? 33 : (phase < 4) ? 79 : 0;
      recv_idle_pct = (phase < 2) ? 79 : (phase < 4) ? 33 : 0;
      for (int n = 0; n < 210; n++) begin
        r = rand_request();
        // full-table rows when capacity is low
        if (caps[phase] <= 6'd1 && n % 7 == 0) begin
          r.op = OP_INSERT; r.has_fixed = 1'b1; r.fixed_status = ST_FULL;
          if (caps[phase] == 6'd1 && shadow_entries.size() == 0) r.has_fixed = 1'b0;
        end
        send_request(r);
      end
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule
`default_nettype wire

/* timestamped_entry_priority_table.f */
src/tetpt_pkg.sv
src/tetpt_cell.sv
src/timestamped_entry_priority_table.sv
src/tetpt_checker.sv
verif/testbench.sv
